/* rtl/tbot_pkg.sv */
// shared types and constants for the triangle/box overlap test
package tbot_pkg;

  localparam int unsigned ADDR_W   = 5;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } fifo_ctl_t;

endpackage

/* rtl/tbot_front.sv */
// front end: box transform, box extents and face tests, registered
module tbot_front #(
  parameter int unsigned CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CW-1:0] lo [3],
  input  logic signed [CW-1:0] hi [3],
  input  logic signed [CW-1:0] v  [3][3],
  output logic                 q_valid,
  output logic signed [CW+2:0] e_q  [3],
  output logic signed [CW+2:0] vq   [3][3],
  output logic                 face_sep_q
);
  localparam int unsigned VW = CW + 3;

  logic signed [VW-1:0] e   [3];
  logic signed [VW-1:0] vv  [3][3];
  logic                 fs;

  always_comb begin
    fs = 1'b0;
    for (int k = 0; k < 3; k++) begin
      e[k] = VW'(hi[k]) - VW'(lo[k]);
      for (int i = 0; i < 3; i++) begin
        vv[i][k] = (VW'(v[i][k]) <<< 1) - (VW'(lo[k]) + VW'(hi[k]));
      end
      if ((vv[0][k] < -e[k] && vv[1][k] < -e[k] && vv[2][k] < -e[k]) ||
          (vv[0][k] > e[k] && vv[1][k] > e[k] && vv[2][k] > e[k])) begin
        fs = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= in_valid && !in_stall;
    end
    if (in_valid && !in_stall) begin
      e_q        <= e;
      vq         <= vv;
      face_sep_q <= fs;
    end
  end
endmodule

/* rtl/tbot_fifo.sv */
// short queue between front and back end
module tbot_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output tbot_pkg::fifo_ctl_t ctl
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign rdata     = mem[rp];
  assign ctl.push  = push;
  assign ctl.pop   = pop;
  assign ctl.full  = (cnt == (AW+1)'(DEPTH));
  assign ctl.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= wdata;
  end
endmodule

/* rtl/tbot_back.sv */
// back end: edge-axis and normal tests as a stall-able pipeline
module tbot_back #(
  parameter int unsigned CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW+2:0] e   [3],
  input  logic signed [CW+2:0] vv  [3][3],
  input  logic                 face_sep,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 overlap
);
  localparam int unsigned VW = CW + 3;
  localparam int unsigned FW = VW + 1;
  localparam int unsigned PW = 2*FW + 3;
  localparam int unsigned NW = 2*FW + 2;
  localparam int unsigned SW = NW + VW + 3;

  // three stages, advance together when output side free
  logic v1, v2, v3;
  logic adv;
  assign adv      = !v3 || !out_stall;
  assign in_stall = !adv;

  // stage 1: edges and products for edge axes, normal components
  logic signed [FW-1:0] f   [3][3];
  logic signed [PW-1:0] r1  [9];
  logic signed [PW-1:0] p1  [9][3];
  logic signed [NW-1:0] n1  [3];
  logic signed [VW-1:0] e1  [3], v01 [3];
  logic                 fs1;

  logic signed [PW-1:0] rc  [9];
  logic signed [PW-1:0] pc  [9][3];
  logic signed [NW-1:0] nc  [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        f[i][k] = FW'(vv[(i+1)%3][k]) - FW'(vv[i][k]);
    for (int i = 0; i < 3; i++) begin
      for (int t = 0; t < 3; t++) begin
        logic signed [FW-1:0] a1, a2;
        a1 = -f[i][(t+2)%3];
        a2 = f[i][(t+1)%3];
        rc[i*3+t] = PW'(e[(t+1)%3]) * PW'(a1 < 0 ? -a1 : a1)
                  + PW'(e[(t+2)%3]) * PW'(a2 < 0 ? -a2 : a2);
        for (int j = 0; j < 3; j++)
          pc[i*3+t][j] = PW'(vv[j][(t+1)%3]) * PW'(a1)
                       + PW'(vv[j][(t+2)%3]) * PW'(a2);
      end
    end
    for (int k = 0; k < 3; k++)
      nc[k] = NW'(f[0][(k+1)%3]) * NW'(f[1][(k+2)%3])
            - NW'(f[0][(k+2)%3]) * NW'(f[1][(k+1)%3]);
  end

  // stage 2: edge-axis decisions, normal dot products
  logic                 es2, fs2;
  logic signed [SW-1:0] s2 [3], rr2 [3];
  logic                 esc;

  always_comb begin
    esc = 1'b0;
    for (int m = 0; m < 9; m++) begin
      if ((p1[m][0] < -r1[m] && p1[m][1] < -r1[m] && p1[m][2] < -r1[m]) ||
          (p1[m][0] > r1[m] && p1[m][1] > r1[m] && p1[m][2] > r1[m]))
        esc = 1'b1;
    end
  end

  // stage 3
  logic signed [SW+1:0] ssum, rsum;
  logic                 ov3;
  always_comb begin
    ssum = (SW+2)'(s2[0]) + (SW+2)'(s2[1]) + (SW+2)'(s2[2]);
    rsum = (SW+2)'(rr2[0]) + (SW+2)'(rr2[1]) + (SW+2)'(rr2[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      r1  <= rc;
      p1  <= pc;
      n1  <= nc;
      e1  <= e;
      v01 <= vv[0];
      fs1 <= face_sep;
      es2 <= esc;
      fs2 <= fs1;
      for (int k = 0; k < 3; k++) begin
        s2[k]  <= SW'(n1[k]) * SW'(v01[k]);
        rr2[k] <= SW'(n1[k] < 0 ? -n1[k] : n1[k]) * SW'(e1[k]);
      end
      ov3 <= !(fs2 || es2 || (rsum < (ssum < 0 ? -ssum : ssum)));
    end
  end

  assign out_valid = v3;
  assign overlap   = ov3;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(overlap))
    else $error("result changed while stalled");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v3 && out_stall)
    else $error("back end stalled without cause");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    v2 && adv |=> v3)
    else $error("item lost in back end");
endmodule

/* rtl/triangle_box_overlap_test_unit.sv */
// top level of the triangle/box overlap test
// path: registered front end, the queue, then 3 back-end stages
// throughput: one triangle per cycle while in_stall is low
// the 4-entry queue absorbs the front stage in flight while the output stalls
// reset: synchronous, clears box registers to 0 and empties all stages and the queue
module triangle_box_overlap_test_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbot_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] ax, ay, az,
  input  logic signed [COORD_WIDTH-1:0] bx, by, bz,
  input  logic signed [COORD_WIDTH-1:0] cx, cy, cz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          overlap
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned VW = CW + 3;
  localparam int unsigned QW = 12*VW + 1;

  logic signed [CW-1:0] lo [3], hi [3];
  logic signed [CW-1:0] vin [3][3];
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign vin[0] = '{ax, ay, az};
  assign vin[1] = '{bx, by, bz};
  assign vin[2] = '{cx, cy, cz};

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '{default: '0};
      hi <= '{default: '0};
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        tbot_pkg::REG_MIN_X: lo[0] <= pwdata[CW-1:0];
        tbot_pkg::REG_MIN_Y: lo[1] <= pwdata[CW-1:0];
        tbot_pkg::REG_MIN_Z: lo[2] <= pwdata[CW-1:0];
        tbot_pkg::REG_MAX_X: hi[0] <= pwdata[CW-1:0];
        tbot_pkg::REG_MAX_Y: hi[1] <= pwdata[CW-1:0];
        tbot_pkg::REG_MAX_Z: hi[2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      tbot_pkg::REG_MIN_X: prdata = 32'(lo[0]);
      tbot_pkg::REG_MIN_Y: prdata = 32'(lo[1]);
      tbot_pkg::REG_MIN_Z: prdata = 32'(lo[2]);
      tbot_pkg::REG_MAX_X: prdata = 32'(hi[0]);
      tbot_pkg::REG_MAX_Y: prdata = 32'(hi[1]);
      tbot_pkg::REG_MAX_Z: prdata = 32'(hi[2]);
      default:             prdata = '0;
    endcase
  end

  logic                 f_valid, f_fs;
  logic signed [VW-1:0] f_e [3], f_v [3][3];
  logic [QW-1:0]        q_wd, q_rd;
  tbot_pkg::fifo_ctl_t  qctl;
  logic                 b_stall;
  logic signed [VW-1:0] b_e [3], b_v [3][3];
  logic                 b_fs;

  // hold off requests while queue could overflow (one in flight)
  logic [2:0] occ;
  assign in_stall = (occ >= 3'd3);

  tbot_front #(.CW(CW)) u_front (
    .clk, .rst, .in_valid, .in_stall, .lo, .hi, .v(vin),
    .q_valid(f_valid), .e_q(f_e), .vq(f_v), .face_sep_q(f_fs)
  );

  assign q_wd = {f_fs, f_e[0], f_e[1], f_e[2],
                 f_v[0][0], f_v[0][1], f_v[0][2],
                 f_v[1][0], f_v[1][1], f_v[1][2],
                 f_v[2][0], f_v[2][1], f_v[2][2]};

  tbot_fifo #(.W(QW), .DEPTH(4)) u_fifo (
    .clk, .rst, .push(f_valid), .wdata(q_wd),
    .pop(!qctl.empty && !b_stall), .rdata(q_rd), .ctl(qctl)
  );

  assign {b_fs, b_e[0], b_e[1], b_e[2],
          b_v[0][0], b_v[0][1], b_v[0][2],
          b_v[1][0], b_v[1][1], b_v[1][2],
          b_v[2][0], b_v[2][1], b_v[2][2]} = q_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + 3'(in_valid && !in_stall) - 3'(qctl.pop);
    end
  end

  tbot_back #(.CW(CW)) u_back (
    .clk, .rst, .in_valid(!qctl.empty), .in_stall(b_stall),
    .e(b_e), .vv(b_v), .face_sep(b_fs),
    .out_valid, .out_stall, .overlap
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qctl.full |-> !qctl.push || qctl.pop)
    else $error("queue overflow");
  a_occ: assert property (@(posedge clk) disable iff (rst)
    qctl.empty |-> occ <= 3'd1)
    else $error("queue occupancy mismatch");
  a_stall_rule: assert property (@(posedge clk) disable iff (rst)
    !qctl.empty && !b_stall |-> qctl.pop)
    else $error("queue not drained");
endmodule

/* tb/testbench.sv */
// self-checking testbench for the triangle/box overlap test unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    shortint v[3][3];
  } tri_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [tbot_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0, cx = 0, cy = 0, cz = 0;
  logic out_valid;
  logic out_stall = 0;
  logic overlap;

  triangle_box_overlap_test_unit #(.COORD_WIDTH(16)) dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .ax, .ay, .az, .bx, .by, .bz, .cx, .cy, .cz,
    .out_valid, .out_stall, .overlap
  );

  shortint box_lo[3], box_hi[3];
  tri_t    pending_tris[$];
  bit      expected_flags[$];
  int      errors = 0, n_checked = 0, n_hits = 0;
  bit      sender_burst = 0;
  int      hold_reqs = 0;
  logic    req_taken = 0, flag_taken = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint labs(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // separating-axis test in doubled coordinates; every term fits in 64 bits
  function automatic bit tri_box_overlaps(tri_t t);
    longint lo[3], hi[3], ext[3], vd[3][3], ed[3][3], ax3[3], pr[3];
    longint mx, mn, rad, s, n;
    bit sep;
    int k1, k2;
    sep = 0;
    for (int k = 0; k < 3; k++) begin
      lo[k] = box_lo[k];
      hi[k] = box_hi[k];
      ext[k] = hi[k] - lo[k];
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        vd[i][k] = 2 * longint'(t.v[i][k]) - (lo[k] + hi[k]);
    for (int k = 0; k < 3; k++) begin
      mx = vd[0][k];
      mn = vd[0][k];
      for (int i = 1; i < 3; i++) begin
        if (vd[i][k] > mx) mx = vd[i][k];
        if (vd[i][k] < mn) mn = vd[i][k];
      end
      if (mx < -ext[k] || mn > ext[k]) sep = 1;
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        ed[i][k] = vd[(i + 1) % 3][k] - vd[i][k];
    // box axis crossed with each edge
    for (int i = 0; i < 3; i++)
      for (int a = 0; a < 3; a++) begin
        ax3[a] = 0;
        ax3[(a + 1) % 3] = -ed[i][(a + 2) % 3];
        ax3[(a + 2) % 3] = ed[i][(a + 1) % 3];
        rad = 0;
        for (int k = 0; k < 3; k++) rad += ext[k] * labs(ax3[k]);
        for (int j = 0; j < 3; j++) begin
          pr[j] = 0;
          for (int k = 0; k < 3; k++) pr[j] += vd[j][k] * ax3[k];
        end
        mx = pr[0];
        mn = pr[0];
        for (int j = 1; j < 3; j++) begin
          if (pr[j] > mx) mx = pr[j];
          if (pr[j] < mn) mn = pr[j];
        end
        if (mx < -rad || mn > rad) sep = 1;
      end
    // triangle plane
    s = 0;
    rad = 0;
    for (int k = 0; k < 3; k++) begin
      k1 = (k + 1) % 3;
      k2 = (k + 2) % 3;
      n = ed[0][k1] * ed[1][k2] - ed[0][k2] * ed[1][k1];
      s += n * vd[0][k];
      rad += labs(n) * ext[k];
    end
    if (rad < labs(s)) sep = 1;
    return !sep;
  endfunction

  function automatic shortint clamp16(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return shortint'(x);
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int span, base, spread;
    int sel;
    sel = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      span = int'(box_hi[k]) - int'(box_lo[k]);
      if (span < 0) span = -span;
      base = int'(box_lo[k]) - span / 2 + int'($urandom_range(0, 2 * span));
      spread = (sel < 5) ? span + 8 : 4000;
      for (int i = 0; i < 3; i++) begin
        if (sel >= 8)
          t.v[i][k] = shortint'($urandom());
        else
          t.v[i][k] = clamp16(base + int'($urandom_range(0, 2 * spread)) - spread);
      end
    end
    return t;
  endfunction

  function automatic tri_t mk_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2);
    tri_t t;
    t.v[0] = '{shortint'(a0), shortint'(a1), shortint'(a2)};
    t.v[1] = '{shortint'(b0), shortint'(b1), shortint'(b2)};
    t.v[2] = '{shortint'(c0), shortint'(c1), shortint'(c2)};
    return t;
  endfunction

  task automatic reg_write(tbot_pkg::reg_idx_t idx, shortint val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= tbot_pkg::ADDR_W'(4 * int'(idx));
    pwdata <= {{16{val[15]}}, val};
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
  endtask

  task automatic set_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_lo = '{shortint'(x0), shortint'(y0), shortint'(z0)};
    box_hi = '{shortint'(x1), shortint'(y1), shortint'(z1)};
    reg_write(tbot_pkg::REG_MIN_X, box_lo[0]);
    reg_write(tbot_pkg::REG_MIN_Y, box_lo[1]);
    reg_write(tbot_pkg::REG_MIN_Z, box_lo[2]);
    reg_write(tbot_pkg::REG_MAX_X, box_hi[0]);
    reg_write(tbot_pkg::REG_MAX_Y, box_hi[1]);
    reg_write(tbot_pkg::REG_MAX_Z, box_hi[2]);
  endtask

  // sender pause: wait for every request to go in and every flag to come back
  task automatic drain();
    do @(posedge clk);
    while (pending_tris.size() != 0 || in_valid || expected_flags.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic push_random(int cnt);
    for (int i = 0; i < cnt; i++) pending_tris.push_back(random_tri());
  endtask

  // stimulus
  initial begin
    box_lo = '{0, 0, 0};
    box_hi = '{0, 0, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // reset box is a point at the origin
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(mk_tri(-10, -10, 0, 10, -10, 0, 0, 10, 0));
    pending_tris.push_back(mk_tri(1, 1, 1, 2, 2, 2, 3, 3, 3));
    drain();
    set_box(-32768, -32768, -32768, 32767, 32767, 32767);
    pending_tris.push_back(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768));
    pending_tris.push_back(mk_tri(32767, 32767, 32767, 32767, -32768, 32767,
                                  -32768, 32767, -32768));
    pending_tris.push_back(mk_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1));
    drain();
    set_box(-100, -100, -100, 100, 100, 100);
    pending_tris.push_back(mk_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                  32767, -32768, 0));
    pending_tris.push_back(mk_tri(100, 0, 0, 200, 0, 0, 150, 50, 0));
    pending_tris.push_back(mk_tri(101, 0, 0, 200, 0, 0, 150, 50, 0));
    pending_tris.push_back(mk_tri(-300, 0, 0, 300, 0, 0, 0, 0, 300));
    pending_tris.push_back(mk_tri(150, 150, -500, 150, 150, 500, -500, 150, 150));
    pending_tris.push_back(mk_tri(-500, -500, 101, 500, -500, 101, 0, 500, 101));
    pending_tris.push_back(mk_tri(-500, -500, 100, 500, -500, 100, 0, 500, 100));
    pending_tris.push_back(mk_tri(-1000, 0, 0, 0, 0, 0, 1000, 0, 0));
    pending_tris.push_back(mk_tri(300, 300, 300, 300, 300, 300, 300, 300, 300));
    pending_tris.push_back(mk_tri(-32768, 32767, 0, 32767, -32768, 0, 32767, 32767, 0));
    pending_tris.push_back(mk_tri(130, 0, 130, 0, 130, 130, 130, 130, 0));
    pending_tris.push_back(mk_tri(90, 0, 90, 0, 90, 90, 90, 90, 0));
    drain();
    // inverted box
    set_box(100, 50, -20, -100, -50, 20);
    pending_tris.push_back(mk_tri(0, 0, 0, 10, 0, 0, 0, 10, 0));
    pending_tris.push_back(mk_tri(0, 0, 0, 1000, 1000, 1000, -1000, 1000, 0));
    push_random(60);
    drain();
    // long output hold-off with the sender never idle, to fill the block
    sender_burst = 1;
    set_box(-2000, -3000, -500, 2500, 1000, 4000);
    hold_reqs++;
    push_random(120);
    drain();
    sender_burst = 0;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_box(32767, 32767, 32767, 32767, 32767, 32767);
        1: set_box(-32768, -32768, -32768, -32768, -32768, -32768);
        2: set_box(-32768, -32768, -32768, 32767, 32767, 32767);
        3: set_box(32767, -32768, 32767, -32768, 32767, -32768);
        4: set_box(-10, -10, -10, 10, 10, 10);
        default: begin
          int lx, ly, lz;
          lx = $urandom_range(0, 65535) - 32768;
          ly = $urandom_range(0, 65535) - 32768;
          lz = $urandom_range(0, 65535) - 32768;
          set_box(lx, ly, lz, clamp16(lx + $urandom_range(0, 20000)),
                  clamp16(ly + $urandom_range(0, 20000)), clamp16(lz + $urandom_range(0, 20000)));
        end
      endcase
      sender_burst = (ph % 3 == 2);
      push_random(50);
      // mid-phase pause of the sender
      drain();
      push_random(50);
      drain();
    end
    repeat (20) @(posedge clk);
    $display("checked %0d overlap flags over 14 box settings, %0d overlapping", n_checked,
             n_hits);
    if (errors == 0 && expected_flags.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // request driver
  int req_gap = 0;
  always @(negedge clk) begin : req_drive
    logic nv;
    tri_t t;
    if (rst) begin
      in_valid <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && req_taken) begin
        nv = 0;
        req_gap = (sender_burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (!nv) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_tris.size() != 0) begin
          t = pending_tris.pop_front();
          {ax, ay, az} <= {t.v[0][0], t.v[0][1], t.v[0][2]};
          {bx, by, bz} <= {t.v[1][0], t.v[1][1], t.v[1][2]};
          {cx, cy, cz} <= {t.v[2][0], t.v[2][1], t.v[2][2]};
          nv = 1;
        end
      end
      in_valid <= nv;
    end
  end

  // result receiver stall
  int flag_wait = 0, hold_cnt = 0, holds_seen = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_cnt = 300;
      end
      if (flag_taken)
        flag_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1;
      end else if (flag_wait > 0) begin
        flag_wait--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    tri_t t;
    bit exp_flag;
    req_taken <= in_valid && !in_stall && !rst;
    flag_taken <= out_valid && !out_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      t.v[0] = '{ax, ay, az};
      t.v[1] = '{bx, by, bz};
      t.v[2] = '{cx, cy, cz};
      expected_flags.push_back(tri_box_overlaps(t));
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_flags.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual overlap=%b", $time, overlap);
        errors++;
      end else begin
        exp_flag = expected_flags.pop_front();
        n_checked++;
        n_hits += exp_flag;
        if (overlap !== exp_flag) begin
          $display("%0t: overlap mismatch, expected %b, actual %b", $time, exp_flag, overlap);
          errors++;
        end
      end
    end
  end

endmodule
